// ----- design/uart_length_framed_receiver_defines.svh -----
// Assertion macros shared by the length-framed receiver.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef UART_LENGTH_FRAMED_RECEIVER_DEFINES_SVH
`define UART_LENGTH_FRAMED_RECEIVER_DEFINES_SVH

// Checks a property on every rising edge outside reset.
`define ULFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define ULFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ulfr_pkg.sv -----
// Shared types and constants of the length-framed serial receiver.
// Depends on nothing; used by the channel interfaces and the top level.
package ulfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef enum logic {
        CFG_HEADER  = 1'b0,
        CFG_TRAILER = 1'b1
    } cfg_index_t;

    localparam byte_t HEADER_RESET  = 8'h55;
    localparam byte_t TRAILER_RESET = 8'hAA;

endpackage

// ----- design/ulfr_if.sv -----
// Valid/ready channel interfaces for received bytes and for frame results.
// Depends on ulfr_pkg for field widths.
interface ulfr_in_if;
    logic                 valid;
    logic                 ready;
    ulfr_pkg::byte_t      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ulfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [ulfr_pkg::KIND_W-1:0]   kind;
    ulfr_pkg::byte_t               func_code;
    ulfr_pkg::byte_t               frame_length;
    ulfr_pkg::byte_t               payload_byte;
    ulfr_pkg::byte_t               byte_index;

    modport source (output valid, output kind, output func_code, output frame_length,
                    output payload_byte, output byte_index, input ready);
    modport sink   (input valid, input kind, input func_code, input frame_length,
                    input payload_byte, input byte_index, output ready);
endinterface

// ----- design/uart_length_framed_receiver.sv -----
// Length-prefixed serial frame receiver: hunts for a header, then reports payload
// bytes and a trailer status. Depends on ulfr_pkg, ulfr_if and the defines header.
//
//   channel  direction  carries
//   rx       in         rx_byte, one received serial byte per item
//   frame    out        kind, func_code, frame_length, payload_byte, byte_index
//   cfg      in         header_byte (index 0), trailer_byte (index 1)
//
// The state update and the result are formed in the cycle of acceptance and the
// result is held in the output register.
// A new item is accepted in every cycle while the output register is empty or taken.
// Reset clears the window, the count and the phase and loads the default bytes.
// A stalled result holds the output register and blocks only further items.
`include "uart_length_framed_receiver_defines.svh"

module uart_length_framed_receiver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  ulfr_pkg::byte_t     cfg_data,
    ulfr_in_if.sink             rx,
    ulfr_out_if.source          frame
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    ulfr_pkg::byte_t header_reg, trailer_reg;
    ulfr_pkg::byte_t win_first_reg, win_first_next;
    ulfr_pkg::byte_t win_second_reg, win_second_next;
    ulfr_pkg::byte_t count_reg, count_next;
    ulfr_pkg::byte_t count_inc;

    logic            res_valid_reg, res_valid_next;
    ulfr_pkg::kind_t res_kind_reg, res_kind_next;
    ulfr_pkg::byte_t res_func_reg, res_func_next;
    ulfr_pkg::byte_t res_len_reg, res_len_next;
    ulfr_pkg::byte_t res_data_reg, res_data_next;
    ulfr_pkg::byte_t res_index_reg, res_index_next;

    logic            accept;

    assign rx.ready  = !res_valid_reg || frame.ready;
    assign accept    = rx.valid && rx.ready;
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        win_first_next  = win_first_reg;
        win_second_next = win_second_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && !frame.ready;
        res_kind_next   = res_kind_reg;
        res_func_next   = res_func_reg;
        res_len_next    = res_len_reg;
        res_data_next   = res_data_reg;
        res_index_next  = res_index_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    win_first_next  = win_second_reg;
                    win_second_next = rx.rx_byte;
                    if (win_first_reg == header_reg)
                    begin
                        count_next = '0;
                        phase_next = (rx.rx_byte != '0) ? PH_PAYLOAD : PH_TRAILER;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = ulfr_pkg::KIND_PAYLOAD;
                    res_func_next  = win_first_reg;
                    res_len_next   = win_second_reg;
                    res_data_next  = rx.rx_byte;
                    res_index_next = count_reg;
                    count_next     = count_inc;
                    if (count_inc >= win_second_reg)
                    begin
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER:
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = (rx.rx_byte == trailer_reg) ? ulfr_pkg::KIND_GOOD
                                                                 : ulfr_pkg::KIND_BAD;
                    res_func_next  = win_first_reg;
                    res_len_next   = win_second_reg;
                    res_data_next  = '0;
                    res_index_next = '0;
                    count_next     = '0;
                    phase_next     = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            header_reg     <= ulfr_pkg::HEADER_RESET;
            trailer_reg    <= ulfr_pkg::TRAILER_RESET;
            win_first_reg  <= '0;
            win_second_reg <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_kind_reg   <= ulfr_pkg::KIND_PAYLOAD;
            res_func_reg   <= '0;
            res_len_reg    <= '0;
            res_data_reg   <= '0;
            res_index_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            win_first_reg  <= win_first_next;
            win_second_reg <= win_second_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
            res_kind_reg   <= res_kind_next;
            res_func_reg   <= res_func_next;
            res_len_reg    <= res_len_next;
            res_data_reg   <= res_data_next;
            res_index_reg  <= res_index_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ulfr_pkg::CFG_HEADER:  header_reg  <= cfg_data;
                    ulfr_pkg::CFG_TRAILER: trailer_reg <= cfg_data;
                    default:               header_reg  <= header_reg;
                endcase
            end
        end
    end

    assign frame.valid        = res_valid_reg;
    assign frame.kind         = res_kind_reg;
    assign frame.func_code    = res_func_reg;
    assign frame.frame_length = res_len_reg;
    assign frame.payload_byte = res_data_reg;
    assign frame.byte_index   = res_index_reg;

    `ULFR_ASSERT(a_count_below_length, (phase_reg == PH_PAYLOAD) |-> (count_reg < win_second_reg), "payload count has reached the frame length")
    `ULFR_ASSERT(a_index_in_frame, (frame.valid && frame.kind == ulfr_pkg::KIND_PAYLOAD) |-> (frame.byte_index < frame.frame_length), "payload index beyond frame length")
    `ULFR_ASSERT(a_trailer_closes, (accept && phase_reg == PH_TRAILER) |=> (phase_reg == PH_HUNT && frame.valid && frame.kind != ulfr_pkg::KIND_PAYLOAD), "trailer byte did not close the frame")
    `ULFR_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!res_valid_reg && phase_reg == PH_HUNT), "receiver not idle in reset")

endmodule
